### design/ray_cylinder_intersect_macros.svh
// Assertion macros for the ray/cylinder intersection block.
// Used by the top level only; no other dependencies.
`ifndef RAY_CYLINDER_INTERSECT_MACROS_SVH
`define RAY_CYLINDER_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rci assertion failed");

// Next-cycle implication, disabled during reset.
`define RCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rci assertion failed");

`endif

### design/rci_pkg.sv
// Shared types and constants for the ray/cylinder intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rci_pkg;

   localparam int unsigned SQRT_STEPS = 64;
   localparam int unsigned DIV_STEPS  = 33;
   localparam logic [30:0] RADIUS_RESET = 31'd65536;

   // Sideband that travels with a ray through the front end and the root unit.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic signed [64:0] h;
      logic [63:0]        a;
   } ray_tag_type;

   // Control bits of one divider lane.
   typedef struct packed {
      logic valid;
      logic hit;
      logic neg;
      logic ovf;
   } div_ctl_type;

   // Result of one divider lane.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic signed [31:0] distance;
   } div_out_type;

   // Assemble a 64x64 product from its four 32x32 partials.
   function automatic logic [127:0] join4(input logic [63:0] p00, input logic [63:0] p01,
                                          input logic [63:0] p10, input logic [63:0] p11);
      logic [127:0] sum;
      sum = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
      return sum;
   endfunction

endpackage

### design/rci_quad.sv
// Front end: products, quadratic coefficients and discriminant (six stages).
// Depends on rci_pkg.
`timescale 1ns / 1ps

module rci_quad (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [31:0]   sx,
   input  logic signed [31:0]   sy,
   input  logic signed [31:0]   dx,
   input  logic signed [31:0]   dy,
   input  logic [30:0]          radius,
   output rci_pkg::ray_tag_type tag_out,
   output logic [127:0]         disc_out
);

   // stage 1: 32x32 products
   logic               v1_ff;
   logic signed [63:0] dxx_ff, dyy_ff, sxx_ff, syy_ff, sxd_ff, syd_ff;
   logic [61:0]        r2_ff;

   // stage 2: a, |s|^2, h
   logic               v2_ff;
   logic [63:0]        a2_ff, ssq2_ff, hmag2_ff, r2b_ff;
   logic signed [64:0] h2_ff;
   logic signed [64:0] h2_in;

   // stage 3: partial products
   logic               v3_ff;
   logic [63:0]        a3_ff;
   logic signed [64:0] h3_ff;
   logic [63:0]        hh00_ff, hh01_ff, hh11_ff;
   logic [63:0]        ar00_ff, ar01_ff, ar10_ff, ar11_ff;
   logic [63:0]        aq00_ff, aq01_ff, aq10_ff, aq11_ff;

   // stage 4: full products
   logic               v4_ff;
   logic [63:0]        a4_ff;
   logic signed [64:0] h4_ff;
   logic [127:0]       hh4_ff, ar4_ff, aq4_ff;

   // stage 5: p and q
   logic               v5_ff;
   logic [63:0]        a5_ff;
   logic signed [64:0] h5_ff;
   logic [127:0]       p5_ff, q5_ff;

   // stage 6: discriminant
   logic               v6_ff, hit6_ff;
   logic [63:0]        a6_ff;
   logic signed [64:0] h6_ff;
   logic [127:0]       d6_ff;
   logic [128:0]       diff_in;

   assign h2_in   = {sxd_ff[63], sxd_ff} + {syd_ff[63], syd_ff};
   assign diff_in = {1'b0, p5_ff} - {1'b0, q5_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      dxx_ff <= dx * dx;
      dyy_ff <= dy * dy;
      sxx_ff <= sx * sx;
      syy_ff <= sy * sy;
      sxd_ff <= sx * dx;
      syd_ff <= sy * dy;
      r2_ff  <= radius * radius;

      a2_ff    <= {1'b0, dxx_ff[62:0]} + {1'b0, dyy_ff[62:0]};
      ssq2_ff  <= {1'b0, sxx_ff[62:0]} + {1'b0, syy_ff[62:0]};
      h2_ff    <= h2_in;
      hmag2_ff <= h2_in[64] ? 64'(-h2_in) : h2_in[63:0];
      r2b_ff   <= {2'b00, r2_ff};

      a3_ff   <= a2_ff;
      h3_ff   <= h2_ff;
      hh00_ff <= hmag2_ff[31:0]  * hmag2_ff[31:0];
      hh01_ff <= hmag2_ff[31:0]  * hmag2_ff[63:32];
      hh11_ff <= hmag2_ff[63:32] * hmag2_ff[63:32];
      ar00_ff <= a2_ff[31:0]  * r2b_ff[31:0];
      ar01_ff <= a2_ff[31:0]  * r2b_ff[63:32];
      ar10_ff <= a2_ff[63:32] * r2b_ff[31:0];
      ar11_ff <= a2_ff[63:32] * r2b_ff[63:32];
      aq00_ff <= a2_ff[31:0]  * ssq2_ff[31:0];
      aq01_ff <= a2_ff[31:0]  * ssq2_ff[63:32];
      aq10_ff <= a2_ff[63:32] * ssq2_ff[31:0];
      aq11_ff <= a2_ff[63:32] * ssq2_ff[63:32];

      a4_ff  <= a3_ff;
      h4_ff  <= h3_ff;
      hh4_ff <= rci_pkg::join4(hh00_ff, hh01_ff, hh01_ff, hh11_ff);
      ar4_ff <= rci_pkg::join4(ar00_ff, ar01_ff, ar10_ff, ar11_ff);
      aq4_ff <= rci_pkg::join4(aq00_ff, aq01_ff, aq10_ff, aq11_ff);

      a5_ff <= a4_ff;
      h5_ff <= h4_ff;
      p5_ff <= hh4_ff + ar4_ff;
      q5_ff <= aq4_ff;

      a6_ff   <= a5_ff;
      h6_ff   <= h5_ff;
      d6_ff   <= diff_in[127:0];
      // miss on a negative discriminant or a ray parallel to the axis
      hit6_ff <= !diff_in[128] && (a5_ff != 64'd0);
   end

   assign tag_out.valid = v6_ff;
   assign tag_out.hit   = hit6_ff;
   assign tag_out.h     = h6_ff;
   assign tag_out.a     = a6_ff;
   assign disc_out      = d6_ff;

endmodule

### design/rci_sqrt.sv
// Integer square root of the 128-bit discriminant, one result bit per stage.
// Depends on rci_pkg.
`timescale 1ns / 1ps

module rci_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  rci_pkg::ray_tag_type tag_in,
   input  logic [127:0]         disc_in,
   output rci_pkg::ray_tag_type tag_out,
   output logic [63:0]          root_out
);

   localparam int unsigned N = rci_pkg::SQRT_STEPS;

   rci_pkg::ray_tag_type tag_ff  [N];
   logic [66:0]          rem_ff  [N];
   logic [63:0]          root_ff [N];
   logic [127:0]         rad_ff  [N];

   for (genvar g = 0; g < N; g++) begin : g_step
      rci_pkg::ray_tag_type tag_prev;
      logic [66:0]          rem_prev, rem_sh, trial, rem_in;
      logic [63:0]          root_prev, root_in;
      logic [127:0]         rad_prev;
      logic                 ge;

      if (g == 0) begin : g_first
         assign tag_prev  = tag_in;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = disc_in;
      end else begin : g_rest
         assign tag_prev  = tag_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh  = {rem_prev[64:0], rad_prev[127:126]};
      assign trial   = {1'b0, root_prev, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? rem_sh - trial : rem_sh;
      assign root_in = {root_prev[62:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g].valid <= 1'b0;
         end else begin
            tag_ff[g] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         rad_ff[g]  <= {rad_prev[125:0], 2'b00};
      end
   end

   assign tag_out  = tag_ff[N-1];
   assign root_out = root_ff[N-1];

endmodule

### design/rci_div.sv
// One root lane: floor(num * 2^16 / a), saturated to signed 32 bits.
// Overflow check, then one quotient bit per stage. Depends on rci_pkg.
`timescale 1ns / 1ps

module rci_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic                 hit_in,
   input  logic signed [65:0]   num_in,
   input  logic [63:0]          a_in,
   output rci_pkg::div_out_type res_out
);

   localparam int unsigned N = rci_pkg::DIV_STEPS;

   // entry stage
   rci_pkg::div_ctl_type ctl0_ff;
   logic [64:0]          rem0_ff;
   logic [32:0]          low0_ff;
   logic [63:0]          a0_ff;
   logic [64:0]          mag_in;

   // step stages
   rci_pkg::div_ctl_type ctl_ff [N];
   logic [64:0]          rem_ff [N];
   logic [32:0]          low_ff [N];
   logic [32:0]          quo_ff [N];
   logic [63:0]          a_ff   [N];

   // output stage
   rci_pkg::div_out_type res_ff;
   rci_pkg::div_ctl_type ctl_last;
   logic [33:0]          qq;
   logic signed [31:0]   dist_in;

   assign mag_in = num_in[65] ? 65'(-num_in) : num_in[64:0];

   // quotient of at least 2^33 saturates whatever the sign
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else begin
         ctl0_ff.valid <= valid_in;
      end
      ctl0_ff.hit <= hit_in;
      ctl0_ff.neg <= num_in[65];
      ctl0_ff.ovf <= {16'd0, mag_in[64:17]} >= a_in;
      rem0_ff     <= {17'd0, mag_in[64:17]};
      low0_ff     <= {mag_in[16:0], 16'd0};
      a0_ff       <= a_in;
   end

   for (genvar g = 0; g < N; g++) begin : g_step
      rci_pkg::div_ctl_type ctl_prev;
      logic [64:0]          rem_prev, rem_sh;
      logic [32:0]          low_prev, quo_prev;
      logic [63:0]          a_prev;
      logic                 ge;

      if (g == 0) begin : g_first
         assign ctl_prev = ctl0_ff;
         assign rem_prev = rem0_ff;
         assign low_prev = low0_ff;
         assign quo_prev = '0;
         assign a_prev   = a0_ff;
      end else begin : g_rest
         assign ctl_prev = ctl_ff[g-1];
         assign rem_prev = rem_ff[g-1];
         assign low_prev = low_ff[g-1];
         assign quo_prev = quo_ff[g-1];
         assign a_prev   = a_ff[g-1];
      end

      assign rem_sh = {rem_prev[63:0], low_prev[32]};
      assign ge     = rem_sh >= {1'b0, a_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g].valid <= 1'b0;
         end else begin
            ctl_ff[g] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= ge ? rem_sh - {1'b0, a_prev} : rem_sh;
         low_ff[g] <= {low_prev[31:0], 1'b0};
         quo_ff[g] <= {quo_prev[31:0], ge};
         a_ff[g]   <= a_prev;
      end
   end

   assign ctl_last = ctl_ff[N-1];
   // negative side rounds the magnitude up so the result is a floor
   assign qq = {1'b0, quo_ff[N-1]} + {33'd0, (rem_ff[N-1] != 65'd0)};

   always_comb begin
      if (!ctl_last.hit) begin
         dist_in = '0;
      end else if (ctl_last.neg) begin
         if (ctl_last.ovf || qq > 34'h080000000) begin
            dist_in = 32'sh80000000;
         end else begin
            dist_in = 32'(-qq);
         end
      end else begin
         if (ctl_last.ovf || quo_ff[N-1] > 33'h07FFFFFFF) begin
            dist_in = 32'sh7FFFFFFF;
         end else begin
            dist_in = quo_ff[N-1][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= ctl_last.valid;
      end
      res_ff.hit      <= ctl_last.hit;
      res_ff.distance <= dist_in;
   end

   assign res_out = res_ff;

endmodule

### design/ray_cylinder_intersect.sv
// Path from start to rsp_valid: front end, square root, numerator register, then
// the two divider lanes in parallel. Throughput: one ray per cycle; busy stays low.
// The square root and the two dividers each resolve one bit per stage.
// Reset (synchronous) clears all stage valid bits and loads radius 1.0.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`include "ray_cylinder_intersect_macros.svh"

module ray_cylinder_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_near_distance,
   output logic signed [31:0] rsp_far_distance
);

   localparam int unsigned LATENCY = 8 + rci_pkg::SQRT_STEPS + rci_pkg::DIV_STEPS + 1;

   logic [30:0]          radius_ff;
   rci_pkg::ray_tag_type quad_tag, sqrt_tag;
   logic [127:0]         disc;
   logic [63:0]          root;

   logic                 nv_ff, nhit_ff;
   logic signed [65:0]   nnear_ff, nfar_ff;
   logic [63:0]          na_ff;
   logic signed [65:0]   negh;

   rci_pkg::div_out_type near_out, far_out;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= rci_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   rci_quad u_quad (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sx       (req_start_x),
      .sy       (req_start_y),
      .dx       (req_dir_x),
      .dy       (req_dir_y),
      .radius   (radius_ff),
      .tag_out  (quad_tag),
      .disc_out (disc)
   );

   rci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .tag_in   (quad_tag),
      .disc_in  (disc),
      .tag_out  (sqrt_tag),
      .root_out (root)
   );

   assign negh = -{sqrt_tag.h[64], sqrt_tag.h};

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else begin
         nv_ff <= sqrt_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      nhit_ff  <= sqrt_tag.hit;
      na_ff    <= sqrt_tag.a;
      nnear_ff <= negh - $signed({2'b00, root});
      nfar_ff  <= negh + $signed({2'b00, root});
   end

   rci_div u_div_near (
      .clock    (clock),
      .reset    (reset),
      .valid_in (nv_ff),
      .hit_in   (nhit_ff),
      .num_in   (nnear_ff),
      .a_in     (na_ff),
      .res_out  (near_out)
   );

   rci_div u_div_far (
      .clock    (clock),
      .reset    (reset),
      .valid_in (nv_ff),
      .hit_in   (nhit_ff),
      .num_in   (nfar_ff),
      .a_in     (na_ff),
      .res_out  (far_out)
   );

   assign rsp_valid         = near_out.valid;
   assign rsp_hit           = near_out.hit;
   assign rsp_near_distance = near_out.distance;
   assign rsp_far_distance  = far_out.distance;

   `RCI_ASSERT_IMPLY(a_lane_sync, clock, reset, near_out.valid || far_out.valid, near_out.valid && far_out.valid && near_out.hit == far_out.hit)
   `RCI_ASSERT_IMPLY(a_root_order, clock, reset, rsp_valid && rsp_hit, rsp_near_distance <= rsp_far_distance)
   `RCI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_near_distance == 32'sd0 && rsp_far_distance == 32'sd0)
   `RCI_ASSERT_IMPLY(a_out_traced, clock, reset, rsp_valid, $past(start, LATENCY))

endmodule
